[rtl/pte_pkg.sv]
package pte_pkg;

    // Hit word layout
    localparam int CHARGE_W  = 4;
    localparam int ROW_W     = 9;
    localparam int COL_W     = 8;
    localparam int CHARGE_LSB = 0;
    localparam int ROW_LSB    = CHARGE_LSB + CHARGE_W;
    localparam int COL_LSB    = ROW_LSB + ROW_W;
    localparam int HIT_KEEP_W = COL_LSB + COL_W;   // charge, row and column bits

    // Track result widths
    localparam int EDGE_W  = 4;
    localparam int SUM_W   = 16;
    localparam int COUNT_W = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Hits beyond this count are ignored for the rest of the track
    localparam int unsigned MAX_HITS = 2400;
    localparam logic [COUNT_W-1:0] MAX_HITS_CNT = COUNT_W'(MAX_HITS);
    localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};

    // Edge mask bit positions
    localparam int EDGE_ROW_UP = 3;
    localparam int EDGE_ROW_DN = 2;
    localparam int EDGE_COL_UP = 1;
    localparam int EDGE_COL_DN = 0;
    localparam logic [EDGE_W-1:0] EDGE_COLS_ONLY = 4'b0011;

    // Register reset values
    localparam logic [ROW_W-1:0] ROW_UPPER_RST = 9'd325;
    localparam logic [ROW_W-1:0] ROW_LOWER_RST = 9'd10;
    localparam logic [COL_W-1:0] COL_UPPER_RST = 8'd77;
    localparam logic [COL_W-1:0] COL_LOWER_RST = 8'd2;
    localparam logic [SUM_W-1:0] THRESHOLD_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_UPPER = 3'd0,
        CFG_ROW_LOWER = 3'd1,
        CFG_COL_UPPER = 3'd2,
        CFG_COL_LOWER = 3'd3,
        CFG_THRESHOLD = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_upper;
        logic [ROW_W-1:0] row_lower;
        logic [COL_W-1:0] col_upper;
        logic [COL_W-1:0] col_lower;
        logic [SUM_W-1:0] charge_threshold;
    } cfg_t;

    typedef struct packed {
        logic                last;
        logic [CHARGE_W-1:0] charge;
        logic [EDGE_W-1:0]   edges;
    } hit_info_t;

    typedef struct packed {
        logic [EDGE_W-1:0]  edge_mask;
        logic [SUM_W-1:0]   charge_sum;
        logic [COUNT_W-1:0] hit_count;
        logic               alpha_flag;
        logic               neutron_flag;
    } track_result_t;

endpackage

[rtl/pixel_track_edge_classifier.sv]
// Pixel track edge classifier: takes one packed hit word per transfer and, on the
// transfer marked tlast, returns one track result with the four-bit edge mask, the
// saturating charge sum, the hit count and the alpha and neutron flags. A hit is
// accepted every clock cycle unless a last hit is held back as below. Each hit is
// taken into the hit register, where the fields are split and compared against the
// limits; the charge add, count and, for a last hit, result capture happen as the
// hit leaves that register. A last hit waits in the hit register while an
// earlier result is still unaccepted, which holds off the input for those cycles.
// Hits after the 2400th of a track are ignored but a tlast on them still closes the
// track. The user must write limits and threshold via cfg_we/cfg_index/cfg_data only
// while no track is in flight; the block does not enforce this.
module pixel_track_edge_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [20:0] hit_word
    input  logic                              s_tlast,   // last_hit
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [3:0] edge_mask,
                                                         // [19:4] charge_sum,
                                                         // [31:20] hit_count
    output logic [1:0]                        m_tuser,   // [0] alpha_flag,
                                                         // [1] neutron_flag
    input  logic                              cfg_we,
    input  logic [pte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pte_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pte_pkg::cfg_t          cfg;
    pte_pkg::hit_info_t     hit;
    pte_pkg::track_result_t result;
    logic                   hit_valid;
    logic                   hit_advance;

    pte_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pte_hit_decode u_hit_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .hit_bits    (s_tdata[pte_pkg::HIT_KEEP_W-1:0]),
        .s_tlast     (s_tlast),
        .cfg         (cfg),
        .hit_valid   (hit_valid),
        .hit         (hit),
        .hit_advance (hit_advance)
    );

    pte_track_acc u_track_acc (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .hit_valid        (hit_valid),
        .hit              (hit),
        .hit_advance      (hit_advance),
        .charge_threshold (cfg.charge_threshold),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .result           (result)
    );

    // Pack the result fields
    assign m_tdata = {result.hit_count, result.charge_sum, result.edge_mask};
    assign m_tuser = {result.neutron_flag, result.alpha_flag};

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("alpha and neutron flags both set");

    a_neutron_no_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[3:0] == 4'd0))
        else $error("neutron flag with an edge touched");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:20] <= pte_pkg::MAX_HITS_CNT))
        else $error("hit count beyond the hit limit");

    a_empty_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31:20] == 12'd0) |-> (m_tdata[19:0] == 20'd0))
        else $error("empty track reports charge or edges");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

[rtl/pte_cfg_regs.sv]
module pte_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pte_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pte_pkg::cfg_t                    cfg
);

    pte_pkg::cfg_t cfg_reg;

    // Load limits on a write; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_upper        <= pte_pkg::ROW_UPPER_RST;
            cfg_reg.row_lower        <= pte_pkg::ROW_LOWER_RST;
            cfg_reg.col_upper        <= pte_pkg::COL_UPPER_RST;
            cfg_reg.col_lower        <= pte_pkg::COL_LOWER_RST;
            cfg_reg.charge_threshold <= pte_pkg::THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (pte_pkg::cfg_index_t'(cfg_index))
                pte_pkg::CFG_ROW_UPPER: cfg_reg.row_upper <= cfg_data[pte_pkg::ROW_W-1:0];
                pte_pkg::CFG_ROW_LOWER: cfg_reg.row_lower <= cfg_data[pte_pkg::ROW_W-1:0];
                pte_pkg::CFG_COL_UPPER: cfg_reg.col_upper <= cfg_data[pte_pkg::COL_W-1:0];
                pte_pkg::CFG_COL_LOWER: cfg_reg.col_lower <= cfg_data[pte_pkg::COL_W-1:0];
                pte_pkg::CFG_THRESHOLD: cfg_reg.charge_threshold <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/pte_hit_decode.sv]
module pte_hit_decode (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pte_pkg::HIT_KEEP_W-1:0]    hit_bits,
    input  logic                              s_tlast,
    input  pte_pkg::cfg_t                     cfg,
    output logic                              hit_valid,
    output pte_pkg::hit_info_t                hit,
    input  logic                              hit_advance
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [pte_pkg::HIT_KEEP_W-1:0] word_reg;
    logic                           last_reg;
    logic [pte_pkg::ROW_W-1:0]      row;
    logic [pte_pkg::COL_W-1:0]      col;

    // Take a new hit when the stage is empty or its hit moves on
    assign s_tready   = !valid_reg || hit_advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the hit payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            word_reg <= hit_bits;
            last_reg <= s_tlast;
        end
    end

    // Split the word and compare against the edge limits
    assign row = word_reg[pte_pkg::ROW_LSB +: pte_pkg::ROW_W];
    assign col = word_reg[pte_pkg::COL_LSB +: pte_pkg::COL_W];

    always_comb begin
        hit.last   = last_reg;
        hit.charge = word_reg[pte_pkg::CHARGE_LSB +: pte_pkg::CHARGE_W];
        hit.edges  = '0;
        hit.edges[pte_pkg::EDGE_ROW_UP] = row > cfg.row_upper;
        hit.edges[pte_pkg::EDGE_ROW_DN] = row < cfg.row_lower;
        hit.edges[pte_pkg::EDGE_COL_UP] = col > cfg.col_upper;
        hit.edges[pte_pkg::EDGE_COL_DN] = col < cfg.col_lower;
    end

    assign hit_valid = valid_reg;

endmodule

[rtl/pte_track_acc.sv]
module pte_track_acc (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            hit_valid,
    input  pte_pkg::hit_info_t              hit,
    output logic                            hit_advance,
    input  logic [pte_pkg::SUM_W-1:0]       charge_threshold,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output pte_pkg::track_result_t          result
);

    logic [pte_pkg::EDGE_W-1:0]  edge_flags_reg,  edge_flags_next;
    logic [pte_pkg::SUM_W-1:0]   charge_acc_reg,  charge_acc_next;
    logic [pte_pkg::COUNT_W-1:0] hits_seen_reg,   hits_seen_next;
    logic                        out_valid_reg,   out_valid_next;
    pte_pkg::track_result_t      result_reg;

    logic                        out_free;
    logic                        take_hit;
    logic [pte_pkg::SUM_W:0]     sum_wide;
    logic [pte_pkg::EDGE_W-1:0]  edges_upd;
    logic [pte_pkg::SUM_W-1:0]   sum_upd;
    logic [pte_pkg::COUNT_W-1:0] count_upd;
    logic                        above;
    logic                        emit;

    // A last hit waits until the result register is free
    assign out_free    = !out_valid_reg || m_tready;
    assign hit_advance = hit_valid && (!hit.last || out_free);
    assign emit        = hit_advance && hit.last;

    // Fold the hit into the track totals, ignoring it past the hit limit
    assign take_hit  = hits_seen_reg < pte_pkg::MAX_HITS_CNT;
    assign sum_wide  = {1'b0, charge_acc_reg} + (pte_pkg::SUM_W+1)'(hit.charge);
    assign edges_upd = take_hit ? (edge_flags_reg | hit.edges) : edge_flags_reg;
    assign sum_upd   = !take_hit ? charge_acc_reg
                     : (sum_wide[pte_pkg::SUM_W] ? pte_pkg::SUM_MAX
                                                 : sum_wide[pte_pkg::SUM_W-1:0]);
    assign count_upd = take_hit ? hits_seen_reg + 1'b1 : hits_seen_reg;
    assign above     = sum_upd > charge_threshold;

    // Advance the totals; clear them after the last hit of a track
    always_comb begin
        edge_flags_next = edge_flags_reg;
        charge_acc_next = charge_acc_reg;
        hits_seen_next  = hits_seen_reg;
        if (emit) begin
            edge_flags_next = '0;
            charge_acc_next = '0;
            hits_seen_next  = '0;
        end else if (hit_advance) begin
            edge_flags_next = edges_upd;
            charge_acc_next = sum_upd;
            hits_seen_next  = count_upd;
        end
    end

    always_comb begin
        priority if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_flags_reg <= '0;
            charge_acc_reg <= '0;
            hits_seen_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            edge_flags_reg <= edge_flags_next;
            charge_acc_reg <= charge_acc_next;
            hits_seen_reg  <= hits_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the track result
    always_ff @(posedge aclk) begin
        if (emit) begin
            result_reg.edge_mask    <= edges_upd;
            result_reg.charge_sum   <= sum_upd;
            result_reg.hit_count    <= count_upd;
            result_reg.alpha_flag   <= (edges_upd == pte_pkg::EDGE_COLS_ONLY) && above;
            result_reg.neutron_flag <= (edges_upd == '0) && above;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule
